[design/rtc_pkg.sv]
// ----------------------------------------------------------------------------
// rtc_pkg
// Shared types, constants and the leap-year function for the RTC calendar.
// ----------------------------------------------------------------------------
package rtc_pkg;

	localparam int YEAR_BITS = 16;

	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SEC = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HALF_MARK     = CFG_IDX_W'(1);

	localparam logic [7:0] TICKS_PER_SEC_RST = 8'd100;
	localparam logic [7:0] HALF_MARK_RST     = 8'd50;

	localparam logic [6:0] SEC_LIMIT  = 7'd60;
	localparam logic [6:0] MIN_LIMIT  = 7'd60;
	localparam logic [5:0] HOUR_LIMIT = 6'd24;

	// multiplicative inverse of 25 modulo 2**16; its low bits serve any narrower year
	localparam logic [YEAR_BITS-1:0] INV_25    = YEAR_BITS'(23593);
	localparam logic [YEAR_BITS-1:0] DIV25_LIM = YEAR_BITS'((2**YEAR_BITS - 1) / 25);

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_LOAD   = 2'd1,
		CMD_TOGGLE = 2'd2
	} cmd_t;

	// divisible by 4, except centuries not divisible by 400
	function automatic logic is_leap(input logic [YEAR_BITS-1:0] y);
		logic [YEAR_BITS-1:0] p;
		logic div25;
		p = y * INV_25;
		div25 = (p <= DIV25_LIM);
		return (y[1:0] == 2'd0) && (!div25 || (y[3:0] == 4'd0));
	endfunction

endpackage

[design/rtc_calendar_tick_top.sv]
// ----------------------------------------------------------------------------
// rtc_calendar_tick_top
// Real-time clock and calendar driven by tick, load and toggle items.
// ----------------------------------------------------------------------------
// An item is held in the input register, then its result goes to the result register.
// Throughput: one item per cycle while out_stall does not hold the result register; the
// calendar step between the input register and the result register sets the figure.
// Reset: 00:00:00 on 1/1/0, prescale and both flags clear, ticks per
// second 100 and half mark 50; no item is pending.
module rtc_calendar_tick_top
	import rtc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,

	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           command,
	input  logic [5:0]           set_second,
	input  logic [5:0]           set_minute,
	input  logic [4:0]           set_hour,
	input  logic [4:0]           set_day,
	input  logic [3:0]           set_month,
	input  logic [15:0]          set_year,

	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [5:0]           second,
	output logic [5:0]           minute,
	output logic [4:0]           hour,
	output logic [4:0]           day,
	output logic [3:0]           month,
	output logic [15:0]          year,
	output logic                 display_flag,
	output logic                 half_flag,

	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	logic [7:0] tps_q;
	logic [7:0] half_mark_q;

	logic       valid_s1;
	logic [1:0] cmd_s1;
	logic [5:0] set_sec_s1;
	logic [5:0] set_min_s1;
	logic [4:0] set_hour_s1;
	logic [4:0] set_day_s1;
	logic [3:0] set_mon_s1;
	logic [15:0] set_year_s1;

	logic                 out_valid_q;
	logic [7:0]           prescale_q;
	logic [5:0]           sec_q;
	logic [5:0]           min_q;
	logic [4:0]           hour_q;
	logic [4:0]           day_q;
	logic [3:0]           mon_q;
	logic [YEAR_BITS-1:0] year_q;
	logic                 disp_q;
	logic                 half_q;

	logic                 adv;
	logic [7:0]           prescale_d;
	logic [5:0]           sec_d;
	logic [5:0]           min_d;
	logic [4:0]           hour_d;
	logic [4:0]           day_d;
	logic [3:0]           mon_d;
	logic [YEAR_BITS-1:0] year_d;
	logic                 disp_d;
	logic                 half_d;

	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q       <= TICKS_PER_SEC_RST;
			half_mark_q <= HALF_MARK_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TICKS_PER_SEC: tps_q <= cfg_data;
				REG_HALF_MARK:     half_mark_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			cmd_s1      <= command;
			set_sec_s1  <= set_second;
			set_min_s1  <= set_minute;
			set_hour_s1 <= set_hour;
			set_day_s1  <= set_day;
			set_mon_s1  <= set_month;
			set_year_s1 <= set_year;
		end
	end

	always_comb begin
		logic [7:0] p;
		logic       sec_tick;
		logic [6:0] s7;
		logic [6:0] m7;
		logic [5:0] h6;
		logic [5:0] d6;
		logic [4:0] mo5;
		logic       roll;

		prescale_d = prescale_q;
		sec_d      = sec_q;
		min_d      = min_q;
		hour_d     = hour_q;
		day_d      = day_q;
		mon_d      = mon_q;
		year_d     = year_q;
		disp_d     = disp_q;
		half_d     = half_q;
		p          = prescale_q + 8'd1;
		sec_tick   = 1'b0;
		s7         = {1'b0, sec_q} + 7'd1;
		m7         = {1'b0, min_q} + 7'd1;
		h6         = {1'b0, hour_q} + 6'd1;
		d6         = {1'b0, day_q} + 6'd1;
		mo5        = {1'b0, mon_q};
		roll       = 1'b0;

		case (cmd_s1)
			CMD_TICK: begin
				if (p == tps_q) begin
					sec_tick = 1'b1;
					disp_d   = 1'b1;
					half_d   = 1'b0;
					p        = 8'd0;
				end
				if (p == half_mark_q)
					half_d = 1'b1;
				prescale_d = p;
				if (sec_tick) begin
					if (s7 < SEC_LIMIT) begin
						sec_d = s7[5:0];
					end else begin
						sec_d = 6'd0;
						if (m7 < MIN_LIMIT) begin
							min_d = m7[5:0];
						end else begin
							min_d = 6'd0;
							if (h6 < HOUR_LIMIT) begin
								hour_d = h6[4:0];
							end else begin
								hour_d = 5'd0;
								if (d6 >= 6'd32)
									roll = 1'b1;
								else if (d6 == 6'd31)
									roll = (mon_q == 4'd4) || (mon_q == 4'd6) ||
										(mon_q == 4'd9) || (mon_q == 4'd11);
								else if (d6 == 6'd30)
									roll = (mon_q == 4'd2);
								else if (d6 == 6'd29)
									roll = (mon_q == 4'd2) && !is_leap(year_q);
								if (roll) begin
									d6  = 6'd1;
									mo5 = mo5 + 5'd1;
								end
								if (mo5 >= 5'd13) begin
									mo5    = 5'd1;
									year_d = year_q + YEAR_BITS'(1);
								end
								day_d = d6[4:0];
								mon_d = mo5[3:0];
							end
						end
					end
				end
			end
			CMD_LOAD: begin
				sec_d  = set_sec_s1;
				min_d  = set_min_s1;
				hour_d = set_hour_s1;
				day_d  = set_day_s1;
				mon_d  = set_mon_s1;
				year_d = set_year_s1[YEAR_BITS-1:0];
			end
			CMD_TOGGLE: begin
				disp_d = !disp_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			prescale_q  <= 8'd0;
			sec_q       <= 6'd0;
			min_q       <= 6'd0;
			hour_q      <= 5'd0;
			day_q       <= 5'd1;
			mon_q       <= 4'd1;
			year_q      <= '0;
			disp_q      <= 1'b0;
			half_q      <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
			prescale_q  <= prescale_d;
			sec_q       <= sec_d;
			min_q       <= min_d;
			hour_q      <= hour_d;
			day_q       <= day_d;
			mon_q       <= mon_d;
			year_q      <= year_d;
			disp_q      <= disp_d;
			half_q      <= half_d;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign second       = sec_q;
	assign minute       = min_q;
	assign hour         = hour_q;
	assign day          = day_q;
	assign month        = mon_q;
	assign year         = 16'(year_q);
	assign display_flag = disp_q;
	assign half_flag    = half_q;

	a_stall_needs_full_out: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid_q && out_stall)
		else $error("input stalled while result register free");

	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_valid_q)
		else $error("advanced item produced no result");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> valid_s1 && $stable(cmd_s1))
		else $error("held item lost from input register");

endmodule

[bench/rtc_calendar_tick_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtc_calendar_tick_top_tb
// Self-checking bench for the real-time clock and calendar. Items go in with
// bursts and gaps and results come out under a changing stall pattern. A
// calendar predictor in the bench computes the time and both flags for each
// item and every result is checked field by field in order. Directed loads
// cover month ends, leap and century years, year wrap and out-of-range fields.
// Random phases then sweep the prescale and half-second settings.
// ----------------------------------------------------------------------------
module rtc_calendar_tick_top_tb;
	import rtc_pkg::*;

	localparam cmd_t CMD_UNUSED = cmd_t'(2'd3);

	typedef struct packed {
		cmd_t        cmd;
		logic [5:0]  sec;
		logic [5:0]  min;
		logic [4:0]  hr;
		logic [4:0]  dom;
		logic [3:0]  mon;
		logic [15:0] yr;
	} item_t;

	typedef struct packed {
		logic [5:0]  sec;
		logic [5:0]  min;
		logic [4:0]  hr;
		logic [4:0]  dom;
		logic [3:0]  mon;
		logic [15:0] yr;
		logic        disp;
		logic        half;
	} reading_t;

	typedef struct {
		logic [7:0]  prescale;
		logic [5:0]  sec;
		logic [5:0]  min;
		logic [4:0]  hr;
		logic [4:0]  dom;
		logic [3:0]  mon;
		logic [15:0] yr;
		logic        disp;
		logic        half;
	} calendar_t;

	typedef enum logic [1:0] {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [1:0]           command = CMD_TICK;
	logic [5:0]           set_second = '0;
	logic [5:0]           set_minute = '0;
	logic [4:0]           set_hour = '0;
	logic [4:0]           set_day = '0;
	logic [3:0]           set_month = '0;
	logic [15:0]          set_year = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [5:0]           second;
	logic [5:0]           minute;
	logic [4:0]           hour;
	logic [4:0]           day;
	logic [3:0]           month;
	logic [15:0]          year;
	logic                 display_flag;
	logic                 half_flag;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_TICKS_PER_SEC;
	logic [7:0]           cfg_data = '0;

	calendar_t   cal;
	logic [7:0]  ticks_per_sec;
	logic [7:0]  half_mark;
	reading_t    readings_due[$];
	reading_t    want;
	int          mismatch_count = 0;
	int          burst_left = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int          stall_span = 0;
	int          notable_years[8] = '{0, 1900, 2000, 2023, 2024, 2100, 2400, 65535};

	rtc_calendar_tick_top DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic step_calendar(input item_t it);
		int s, mi, h, d, m;
		bit roll, leap;
		case (it.cmd)
			CMD_TICK: begin
				cal.prescale = cal.prescale + 8'd1;
				if (cal.prescale == ticks_per_sec) begin
					cal.prescale = '0;
					cal.disp = 1'b1;
					cal.half = 1'b0;
					s = cal.sec + 1;
					if (s < 60) cal.sec = 6'(s);
					else begin
						cal.sec = '0;
						mi = cal.min + 1;
						if (mi < 60) cal.min = 6'(mi);
						else begin
							cal.min = '0;
							h = cal.hr + 1;
							if (h < 24) cal.hr = 5'(h);
							else begin
								cal.hr = '0;
								d = cal.dom + 1;
								m = cal.mon;
								leap = (cal.yr % 100 == 0) ? (cal.yr % 400 == 0) : (cal.yr % 4 == 0);
								roll = 1'b0;
								if (d >= 32) roll = 1'b1;
								else if (d == 31) roll = (m == 4 || m == 6 || m == 9 || m == 11);
								else if (d == 30) roll = (m == 2);
								else if (d == 29) roll = (m == 2) && !leap;
								if (roll) begin
									d = 1;
									m = m + 1;
								end
								if (m >= 13) begin
									m = 1;
									cal.yr = cal.yr + 16'd1;
								end
								cal.dom = 5'(d);
								cal.mon = 4'(m);
							end
						end
					end
				end
				if (cal.prescale == half_mark) cal.half = 1'b1;
			end
			CMD_LOAD: begin
				cal.sec = it.sec;
				cal.min = it.min;
				cal.hr  = it.hr;
				cal.dom = it.dom;
				cal.mon = it.mon;
				cal.yr  = it.yr;
			end
			CMD_TOGGLE: cal.disp = !cal.disp;
			default: ;
		endcase
		readings_due.push_back(reading_t'{cal.sec, cal.min, cal.hr, cal.dom, cal.mon, cal.yr,
			cal.disp, cal.half});
	endtask

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 20) $display("%0t mismatch: %s", $realtime, what);
	endtask

	task automatic check_field(input string name, input int unsigned got, input int unsigned exp_val);
		if (got != exp_val)
			report_mismatch($sformatf("%s got %0d expected %0d", name, got, exp_val));
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (readings_due.size() == 0) report_mismatch("result with no item pending");
			else begin
				want = readings_due.pop_front();
				check_field("second", second, want.sec);
				check_field("minute", minute, want.min);
				check_field("hour", hour, want.hr);
				check_field("day", day, want.dom);
				check_field("month", month, want.mon);
				check_field("year", year, want.yr);
				check_field("display_flag", display_flag, want.disp);
				check_field("half_flag", half_flag, want.half);
			end
		end
	end

	always @(posedge clk) begin
		if (stall_span == 0) begin
			stall_mode <= stall_mode_t'($urandom_range(0, 3));
			stall_span <= $urandom_range(20, 80);
		end else begin
			stall_span <= stall_span - 1;
		end
		case (stall_mode)
			STALL_NONE:  out_stall <= 1'b0;
			STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
			STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
			default:     out_stall <= (stall_span % 4 == 0);
		endcase
	end

	task automatic send_item(input item_t it);
		in_valid   <= 1'b1;
		command    <= it.cmd;
		set_second <= it.sec;
		set_minute <= it.min;
		set_hour   <= it.hr;
		set_day    <= it.dom;
		set_month  <= it.mon;
		set_year   <= it.yr;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		step_calendar(it);
	endtask

	task automatic pace_sender();
		if (burst_left > 0) burst_left--;
		else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
		end
	endtask

	task automatic wait_for_readings();
		in_valid <= 1'b0;
		while (readings_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_config(input logic [7:0] tps, input logic [7:0] mark);
		cfg_valid <= 1'b1;
		cfg_index <= REG_TICKS_PER_SEC;
		cfg_data  <= tps;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= REG_HALF_MARK;
		cfg_data  <= mark;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		ticks_per_sec = tps;
		half_mark = mark;
	endtask

	task automatic load_and_tick(input int s, input int mi, input int h, input int d,
		input int mo, input int y);
		item_t it;
		it = '{cmd: CMD_LOAD, sec: 6'(s), min: 6'(mi), hr: 5'(h), dom: 5'(d), mon: 4'(mo),
			yr: 16'(y)};
		send_item(it);
		it.cmd = CMD_TICK;
		send_item(it);
	endtask

	function automatic item_t random_item();
		item_t it;
		int unsigned pick;
		it.cmd = CMD_TICK;
		it.sec = 6'($urandom);
		it.min = 6'($urandom);
		it.hr  = 5'($urandom);
		it.dom = 5'($urandom);
		it.mon = 4'($urandom);
		it.yr  = 16'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			it.cmd = CMD_LOAD;
			it.sec = 6'($urandom_range(56, 59));
			it.min = 6'(($urandom_range(0, 3) != 0) ? 59 : $urandom_range(0, 59));
			it.hr  = 5'(($urandom_range(0, 3) != 0) ? 23 : $urandom_range(0, 23));
			it.dom = 5'($urandom_range(27, 31));
			it.mon = 4'($urandom_range(1, 12));
			it.yr  = 16'(notable_years[$urandom_range(0, 7)]);
		end else if (pick < 14) it.cmd = CMD_LOAD;
		else if (pick < 22) it.cmd = CMD_TOGGLE;
		else if (pick < 25) it.cmd = CMD_UNUSED;
		return it;
	endfunction

	task automatic run_phase(input logic [7:0] tps, input logic [7:0] mark, input int count);
		wait_for_readings();
		write_config(tps, mark);
		for (int n = 0; n < count; n++) begin
			if (n == count / 2) wait_for_readings();
			send_item(random_item());
			pace_sender();
		end
	endtask

	task automatic test_flag_commands();
		item_t it;
		it = '{cmd: CMD_UNUSED, default: '0};
		send_item(it);
		it.cmd = CMD_TOGGLE;
		send_item(it);
		send_item(it);
	endtask

	task automatic test_calendar_rollover();
		wait_for_readings();
		write_config(8'd1, 8'd0);
		load_and_tick(59, 59, 23, 31, 12, 65535);
		load_and_tick(59, 59, 23, 28, 2, 2000);
		load_and_tick(59, 59, 23, 28, 2, 1900);
		load_and_tick(59, 59, 23, 28, 2, 2024);
		load_and_tick(59, 59, 23, 29, 2, 2024);
		load_and_tick(59, 59, 23, 28, 2, 2023);
		load_and_tick(59, 59, 23, 30, 4, 2023);
	endtask

	task automatic test_out_of_range_fields();
		load_and_tick(63, 63, 31, 31, 15, 65535);
		load_and_tick(59, 59, 23, 0, 0, 5);
		load_and_tick(59, 59, 23, 30, 0, 5);
		load_and_tick(59, 59, 23, 5, 13, 7);
	endtask

	task automatic test_prescale_sweep();
		run_phase(8'd100, 8'd50, 60);
		run_phase(8'd2, 8'd1, 60);
		run_phase(8'd255, 8'd254, 260);
		run_phase(8'd0, 8'd255, 260);
		run_phase(8'd3, 8'd2, 80);
		run_phase(8'($urandom_range(2, 40)), 8'($urandom_range(0, 255)), 80);
	endtask

	initial begin
		cal = '{prescale: '0, sec: '0, min: '0, hr: '0, dom: 5'd1, mon: 4'd1, yr: '0,
			disp: 1'b0, half: 1'b0};
		ticks_per_sec = TICKS_PER_SEC_RST;
		half_mark = HALF_MARK_RST;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_flag_commands();
		test_calendar_rollover();
		test_out_of_range_fields();
		test_prescale_sweep();
		wait_for_readings();
		if (mismatch_count == 0)
			$display("rtc_calendar_tick_top regression: pass");
		else
			$display("rtc_calendar_tick_top regression: fail");
		$finish;
	end

	initial begin
		#2ms;
		$display("rtc_calendar_tick_top regression: fail");
		$finish;
	end

endmodule

[sim.f]
design/rtc_pkg.sv
design/rtc_calendar_tick_top.sv
bench/rtc_calendar_tick_top_tb.sv
